FILE: src/multi_mode_checksum_crc16_engine_defines.svh
// assertion helpers for the multi-mode check engine
`ifndef MULTI_MODE_CHECKSUM_CRC16_ENGINE_DEFINES_SVH
`define MULTI_MODE_CHECKSUM_CRC16_ENGINE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MMCC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("check engine assertion failed");

// next-cycle implication, disabled during reset
`define MMCC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check engine assertion failed");

`endif

FILE: src/mmcc_pkg.sv
`default_nettype none

package mmcc_pkg;

   localparam int DataWidth  = 8;
   localparam int CheckWidth = 32;
   localparam int CrcWidth   = 16;
   localparam int ModeWidth  = 3;
   localparam int ShiftWidth = 8;
   localparam int CsrIdxWidth  = 2;
   localparam int CsrDataWidth = 16;

   // check_mode codes
   localparam logic [ModeWidth-1:0] MODE_SUM8  = 3'd0;
   localparam logic [ModeWidth-1:0] MODE_SUM16 = 3'd1;
   localparam logic [ModeWidth-1:0] MODE_SUM32 = 3'd2;
   localparam logic [ModeWidth-1:0] MODE_RCRC  = 3'd3;
   localparam logic [ModeWidth-1:0] MODE_CCITT = 3'd4;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_CHECK_MODE = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_CRC_POLY   = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_SHIFTS     = 2'd2;

   localparam logic [ModeWidth-1:0]  RESET_MODE   = MODE_RCRC;
   localparam logic [CrcWidth-1:0]   RESET_POLY   = 16'hA001;
   localparam logic [ShiftWidth-1:0] RESET_SHIFTS = 8'd8;
   localparam logic [CheckWidth-1:0] CCITT_START  = 32'h0000_FFFF;

   typedef struct packed {
      logic [ModeWidth-1:0]  mode;
      logic [CrcWidth-1:0]   poly;
      logic [ShiftWidth-1:0] shifts;
   } cfg_type;

   typedef enum logic [2:0] {
      ALU_SUM8,
      ALU_SUM16,
      ALU_SUM32,
      ALU_XOR16,
      ALU_SHIFT,
      ALU_CCITT,
      ALU_PASS
   } alu_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

FILE: src/mmcc_csr.sv
`default_nettype none

module mmcc_csr import mmcc_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_valid,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_data,
   output cfg_type                      cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CHECK_MODE: cfg_in.mode   = csr_data[ModeWidth-1:0];
            CSR_CRC_POLY:   cfg_in.poly   = csr_data[CrcWidth-1:0];
            CSR_SHIFTS:     cfg_in.shifts = csr_data[ShiftWidth-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode   <= RESET_MODE;
         cfg_ff.poly   <= RESET_POLY;
         cfg_ff.shifts <= RESET_SHIFTS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: src/mmcc_alu.sv
`default_nettype none

module mmcc_alu import mmcc_pkg::*; (
   input  alu_op_type                 op,
   input  wire logic [CheckWidth-1:0] base,
   input  wire logic [DataWidth-1:0]  data_byte,
   input  wire logic [CrcWidth-1:0]   poly,
   output logic      [CheckWidth-1:0] result
);

   logic [DataWidth-1:0] x0;
   logic [DataWidth-1:0] x1;
   logic [CrcWidth-1:0]  shifted;
   logic [CrcWidth-1:0]  ccitt;
   logic [DataWidth-1:0] sum8;
   logic [CrcWidth-1:0]  sum16;

   always_comb begin
      // single step of the reflected crc
      shifted = {1'b0, base[CrcWidth-1:1]} ^ (base[0] ? poly : '0);

      // table-free ccitt byte update
      x0    = base[CrcWidth-1:DataWidth] ^ data_byte;
      x1    = x0 ^ {4'b0, x0[7:4]};
      ccitt = {base[DataWidth-1:0], 8'b0} ^ {x1[3:0], 12'b0}
            ^ {3'b0, x1, 5'b0} ^ {8'b0, x1};

      sum8  = base[DataWidth-1:0] + data_byte;
      sum16 = base[CrcWidth-1:0] + {8'b0, data_byte};

      case (op)
         ALU_SUM8:  result = {24'b0, sum8};
         ALU_SUM16: result = {16'b0, sum16};
         ALU_SUM32: result = base + {24'b0, data_byte};
         ALU_XOR16: result = {16'b0, base[CrcWidth-1:0] ^ {8'b0, data_byte}};
         ALU_SHIFT: result = {16'b0, shifted};
         ALU_CCITT: result = {16'b0, ccitt};
         ALU_PASS:  result = base;
         default:   result = base;
      endcase
   end

endmodule

`default_nettype wire

FILE: src/multi_mode_checksum_crc16_engine.sv
`default_nettype none

// Multi-mode message check engine. Message bytes come in one transaction
// at a time on the req_ channel, each with a first mark (restart the check
// value: 0, or 0xFFFF in ccitt mode) and a last mark (deliver the finished
// value on the rsp_ channel, narrower checks zero-extended to 32 bits). check_mode picks an
// 8/16/32-bit wrapping byte sum, a reflected crc16 that shifts right
// shifts_per_byte times per byte with crc_polynomial, or the ccitt crc16;
// codes 5..7 just hold the value. One shared step unit applies the byte
// on the accept cycle, then in reflected crc mode runs one crc shift per
// cycle, shifts_per_byte times, then a finish step hands a last byte's
// value to the output register. req_ready is low while a byte is in
// flight. A finished value waiting on rsp_ready does not hold off the
// next byte; when that byte is also a last byte, the engine waits in its
// finish cycle until the output register frees, and req_ready stays low
// meanwhile. Registers are written at csr_index 0 (check_mode),
// 1 (crc_polynomial), 2 (shifts_per_byte); the user must write them only
// while the engine is idle, the block itself does not enforce it;
// csr_ready is always high.

`include "multi_mode_checksum_crc16_engine_defines.svh"

module multi_mode_checksum_crc16_engine import mmcc_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // byte input
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [DataWidth-1:0]    req_data_byte,
   input  wire logic                    req_first_byte,
   input  wire logic                    req_last_byte,
   // result output
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic      [CheckWidth-1:0]   rsp_check_value,
   // register writes
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_data
);

   cfg_type cfg;

   state_type             state_ff, state_in;
   logic [ShiftWidth-1:0] count_ff, count_in;
   logic [CheckWidth-1:0] running_ff, running_in;
   logic                  last_ff, last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CheckWidth-1:0] rsp_value_ff, rsp_value_in;

   alu_op_type            alu_op;
   logic [CheckWidth-1:0] alu_base;
   logic [CheckWidth-1:0] alu_result;
   logic [CheckWidth-1:0] restart_base;
   logic                  req_accept;
   logic                  slot_free;

   // register file, always ready
   assign csr_ready = 1'b1;

   mmcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // shared step unit
   mmcc_alu u_alu (
      .op        (alu_op),
      .base      (alu_base),
      .data_byte (req_data_byte),
      .poly      (cfg.poly),
      .result    (alu_result)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   // output register can take a new value this cycle
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   // restart value applies only when the first mark is set
   always_comb begin
      if (req_first_byte) begin
         restart_base = (cfg.mode == MODE_CCITT) ? CCITT_START : '0;
      end else begin
         restart_base = running_ff;
      end
   end

   // sequencer: next state, step unit control, register updates
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      running_in   = running_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      alu_op       = ALU_PASS;
      alu_base     = restart_base;

      case (state_ff)
         ST_IDLE: begin
            case (cfg.mode)
               MODE_SUM8:  alu_op = ALU_SUM8;
               MODE_SUM16: alu_op = ALU_SUM16;
               MODE_SUM32: alu_op = ALU_SUM32;
               MODE_RCRC:  alu_op = ALU_XOR16;
               MODE_CCITT: alu_op = ALU_CCITT;
               default:    alu_op = ALU_PASS;
            endcase
            if (req_accept) begin
               running_in = alu_result;
               last_in    = req_last_byte;
               count_in   = cfg.shifts;
               // reflected crc with a nonzero shift count runs the shift loop
               if (cfg.mode == MODE_RCRC && cfg.shifts != '0) begin
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SHIFT: begin
            alu_op     = ALU_SHIFT;
            alu_base   = running_ff;
            running_in = alu_result;
            count_in   = count_ff - 8'd1;
            if (count_ff == 8'd1) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            alu_base = running_ff;
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               // hand the finished value to the output register
               rsp_valid_in = 1'b1;
               rsp_value_in = running_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         running_ff   <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         running_ff   <= running_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_check_value = rsp_value_ff;

   // shift loop never runs with an exhausted count
   `MMCC_ASSERT_NOW(a_shift_count_live, state_ff == ST_SHIFT, count_ff != '0)

   // count steps down by one per shift cycle
   `MMCC_ASSERT_NOW(a_shift_count_step,
      state_ff == ST_SHIFT && $past(state_ff) == ST_SHIFT,
      count_ff == $past(count_ff) - 8'd1)

   // an accepted byte always keeps the engine busy the next cycle
   `MMCC_ASSERT_NEXT(a_busy_after_accept, req_accept, !req_ready)

   // a new result only comes from the finish step of a last byte
   `MMCC_ASSERT_NOW(a_result_source, $rose(rsp_valid_ff),
      $past(state_ff) == ST_FINISH && $past(last_ff))

endmodule

`default_nettype wire

FILE: bench/multi_mode_checksum_crc16_engine_test.sv
module multi_mode_checksum_crc16_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mmcc_pkg::*;

   // bench timing and sizing
   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 11;
   localparam int MAX_IDLE      = 13;
   localparam int STALL_LIMIT   = 4000;
   localparam int RANDOM_ITEMS  = 1300;
   localparam int LONG_HOLD     = 400;
   localparam int FLOOD_ITEMS   = 16;

   // mode codes with no check of their own: the value just holds
   localparam logic [ModeWidth-1:0] MODE_SPARE_LO = 3'd5;
   localparam logic [ModeWidth-1:0] MODE_SPARE_HI = 3'd7;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [DataWidth-1:0]    req_data_byte;
   logic                    req_first_byte;
   logic                    req_last_byte;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [CheckWidth-1:0]   rsp_check_value;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CsrIdxWidth-1:0]  csr_index;
   logic [CsrDataWidth-1:0] csr_data;

   // shadow copy of the engine registers and its running value
   logic [ModeWidth-1:0]    cur_mode;
   logic [CrcWidth-1:0]     cur_poly;
   logic [ShiftWidth-1:0]   cur_shifts;
   logic [CheckWidth-1:0]   check_acc;

   // finished check values still owed by the engine, oldest first
   logic [CheckWidth-1:0]   expected_checks[$];
   logic [CheckWidth-1:0]   owed_value;

   int fail_count    = 0;
   int idle_cycles   = 0;
   int req_max_gap   = MAX_IDLE;
   int rsp_max_wait  = MAX_IDLE;
   int rsp_wait_left = 0;
   int rsp_hold_left = 0;
   int random_sent   = 0;

   multi_mode_checksum_crc16_engine dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_first_byte  (req_first_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_check_value (rsp_check_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   // reflected crc: fold the byte in, then shift right, folding the
   // polynomial in whenever a one drops off the bottom
   function automatic logic [CrcWidth-1:0] reflected_crc_byte(
      input logic [CrcWidth-1:0]   crc,
      input logic [DataWidth-1:0]  data,
      input logic [CrcWidth-1:0]   poly,
      input logic [ShiftWidth-1:0] shifts);
      int   n;
      logic dropped;
      crc = crc ^ {8'h00, data};
      for (n = 0; n < int'(shifts); n++) begin
         dropped = crc[0];
         crc = crc >> 1;
         if (dropped)
            crc = crc ^ poly;
      end
      return crc;
   endfunction

   // table-free ccitt byte update, 16-bit arithmetic does the masking
   function automatic logic [CrcWidth-1:0] ccitt_crc_byte(
      input logic [CrcWidth-1:0]  crc,
      input logic [DataWidth-1:0] data);
      logic [CrcWidth-1:0] x;
      x = {8'h00, crc[15:8] ^ data};
      x = x ^ (x >> 4);
      return {crc[7:0], 8'h00} ^ (x << 12) ^ (x << 5) ^ x;
   endfunction

   // advance the running check by one accepted byte
   function automatic void predict_byte(
      input logic [DataWidth-1:0] data,
      input logic                 first,
      input logic                 last);
      if (first)
         check_acc = (cur_mode == MODE_CCITT) ? CCITT_START : '0;
      case (cur_mode)
         MODE_SUM8:  check_acc = {24'h0, check_acc[7:0] + data};
         MODE_SUM16: check_acc = {16'h0, check_acc[15:0] + {8'h00, data}};
         MODE_SUM32: check_acc = check_acc + {24'h0, data};
         MODE_RCRC: begin
            check_acc = {16'h0, reflected_crc_byte(check_acc[15:0], data,
                                                   cur_poly, cur_shifts)};
         end
         MODE_CCITT: check_acc = {16'h0, ccitt_crc_byte(check_acc[15:0], data)};
         default: ;
      endcase
      if (last)
         expected_checks.push_back(check_acc);
   endfunction

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------

   // receiver: long hold-off first, then the per-result random stall
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_ready = 1'b0;
            rsp_hold_left--;
         end else if (rsp_wait_left > 0) begin
            rsp_ready = 1'b0;
            rsp_wait_left--;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // compare every result transaction against the oldest owed value
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_checks.size() == 0) begin
            $display("%0t: check value %h with no byte marked last pending",
                     $time, rsp_check_value);
            fail_count++;
         end else begin
            owed_value = expected_checks.pop_front();
            if (rsp_check_value !== owed_value) begin
               $display("%0t: check_value expected %h actual %h",
                        $time, owed_value, rsp_check_value);
               fail_count++;
            end
         end
         // stall before taking the next result
         rsp_wait_left = $urandom_range(0, rsp_max_wait);
      end
   end

   // watchdog: any transaction on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // drivers; every task starts and ends just after a falling edge
   // ------------------------------------------------------------------

   // offer one byte, hold it until taken; valid stays up for a
   // back-to-back byte and drops only when a gap is drawn
   task automatic send_byte(
      input logic [DataWidth-1:0] data,
      input logic                 first,
      input logic                 last);
      int gap;
      gap = $urandom_range(0, req_max_gap);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_data_byte  = data;
      req_first_byte = first;
      req_last_byte  = last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_byte(data, first, last);
      @(negedge clock);
   endtask

   // sender pauses until every owed value is in, then lets a byte that
   // closes no message run through the shift loop
   task automatic wait_for_idle();
      req_valid = 1'b0;
      while (expected_checks.size() != 0) @(negedge clock);
      repeat (int'(cur_shifts) + 16) @(negedge clock);
   endtask

   // one register write transaction, only called with the engine idle
   task automatic write_reg(
      input logic [CsrIdxWidth-1:0]  idx,
      input logic [CsrDataWidth-1:0] value);
      req_valid = 1'b0;
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_CHECK_MODE: cur_mode   = value[ModeWidth-1:0];
         CSR_CRC_POLY:   cur_poly   = value;
         CSR_SHIFTS:     cur_shifts = value[ShiftWidth-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [DataWidth-1:0] random_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // mostly well-formed messages, some loose bytes with random marks
   task automatic send_random_message(output int sent);
      int k;
      int len;
      if ($urandom_range(0, 99) < 85) begin
         len = $urandom_range(1, 12);
         for (k = 0; k < len; k++)
            send_byte(random_byte(), k == 0, k == len - 1);
      end else begin
         len = $urandom_range(1, 6);
         for (k = 0; k < len; k++)
            send_byte(random_byte(), 1'($urandom), 1'($urandom));
      end
      sent = len;
   endtask

   // new register setting; unused upper data bits get noise now and then
   task automatic randomize_config();
      logic [ModeWidth-1:0]  mode;
      logic [CrcWidth-1:0]   poly;
      logic [ShiftWidth-1:0] shifts;
      int                    pick;
      pick = $urandom_range(0, 15);
      if (pick < 13)
         mode = 3'(pick % 5);
      else
         mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      case ($urandom_range(0, 7))
         0:       poly = 16'h0000;
         1:       poly = 16'hFFFF;
         2:       poly = RESET_POLY;
         default: poly = 16'($urandom);
      endcase
      // long shift counts are slow, so keep them rare
      case ($urandom_range(0, 11))
         0:       shifts = 8'd255;
         1:       shifts = 8'($urandom_range(17, 254));
         2:       shifts = 8'd0;
         default: shifts = 8'($urandom_range(1, 16));
      endcase
      wait_for_idle();
      write_reg(CSR_CHECK_MODE, {($urandom_range(0, 1) ? 13'($urandom) : 13'h0), mode});
      write_reg(CSR_CRC_POLY, poly);
      write_reg(CSR_SHIFTS, {($urandom_range(0, 1) ? 8'($urandom) : 8'h00), shifts});
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // no restart since reset: the value runs on from 0 even in ccitt mode,
   // then the reset polynomial and shift count in reflected crc mode
   task automatic test_start_without_restart();
      write_reg(CSR_CHECK_MODE, 16'(MODE_CCITT));
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b1);
      wait_for_idle();
      write_reg(CSR_CHECK_MODE, 16'(MODE_RCRC));
      send_byte(8'hA5, 1'b1, 1'b1);
   endtask

   // every mode code, the unused ones included; 0xFF + 0x80 wraps sum8
   task automatic test_every_mode();
      int m;
      for (m = int'(MODE_SUM8); m <= int'(MODE_SPARE_HI); m++) begin
         wait_for_idle();
         write_reg(CSR_CHECK_MODE, 16'(m));
         if (m < int'(MODE_SPARE_LO)) begin
            send_byte(8'hFF, 1'b1, 1'b0);
            send_byte(8'h80, 1'b0, 1'b1);
         end else begin
            send_byte(8'h3C, 1'b1, 1'b1);
         end
      end
   endtask

   // switch mode inside a message: the new mode works on its own width
   task automatic test_mode_switch_mid_message();
      wait_for_idle();
      write_reg(CSR_CHECK_MODE, 16'(MODE_SUM16));
      send_byte(8'hFF, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      wait_for_idle();
      write_reg(CSR_CHECK_MODE, 16'(MODE_SUM8));
      send_byte(8'h10, 1'b0, 1'b1);
      wait_for_idle();
      write_reg(CSR_CHECK_MODE, 16'(MODE_CCITT));
      send_byte(8'h31, 1'b1, 1'b0);
      wait_for_idle();
      write_reg(CSR_CHECK_MODE, 16'(MODE_SUM32));
      send_byte(8'hFF, 1'b0, 1'b1);
   endtask

   // zero shift count only folds the byte in; longest count; polynomial
   // extremes
   task automatic test_shift_extremes();
      wait_for_idle();
      write_reg(CSR_CHECK_MODE, 16'(MODE_RCRC));
      write_reg(CSR_CRC_POLY, 16'hFFFF);
      write_reg(CSR_SHIFTS, 16'd0);
      send_byte(8'h5A, 1'b1, 1'b1);
      wait_for_idle();
      write_reg(CSR_SHIFTS, 16'd255);
      send_byte(8'hFF, 1'b1, 1'b1);
      wait_for_idle();
      write_reg(CSR_CRC_POLY, 16'h0000);
      write_reg(CSR_SHIFTS, 16'd16);
      send_byte(8'h81, 1'b1, 1'b1);
   endtask

   // receiver holds off while single-byte messages keep coming, so the
   // result register fills and the engine stalls its input
   task automatic test_output_backpressure();
      int k;
      wait_for_idle();
      write_reg(CSR_CHECK_MODE, 16'(MODE_SUM16));
      req_max_gap   = 0;
      rsp_hold_left = LONG_HOLD;
      for (k = 0; k < FLOOD_ITEMS; k++)
         send_byte(random_byte(), 1'b1, 1'b1);
      random_sent += FLOOD_ITEMS;
      req_max_gap = MAX_IDLE;
      wait_for_idle();
   endtask

   // phases of random messages, each under a fresh register setting and
   // idling pattern, until the byte budget is used up
   task automatic test_random_traffic(input int budget);
      int phase_left;
      int sent;
      int stop_at;
      stop_at = random_sent + budget;
      while (random_sent < stop_at) begin
         randomize_config();
         case ($urandom_range(0, 3))
            0:       begin req_max_gap = 0;        rsp_max_wait = 0;        end
            1:       begin req_max_gap = 0;        rsp_max_wait = MAX_IDLE; end
            2:       begin req_max_gap = MAX_IDLE; rsp_max_wait = 0;        end
            default: begin req_max_gap = MAX_IDLE; rsp_max_wait = MAX_IDLE; end
         endcase
         phase_left = $urandom_range(30, 70);
         while (phase_left > 0 && random_sent < stop_at) begin
            send_random_message(sent);
            phase_left  -= sent;
            random_sent += sent;
         end
      end
      req_max_gap  = MAX_IDLE;
      rsp_max_wait = MAX_IDLE;
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = '0;
      req_first_byte = 1'b0;
      req_last_byte  = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      cur_mode       = RESET_MODE;
      cur_poly       = RESET_POLY;
      cur_shifts     = RESET_SHIFTS;
      check_acc      = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_start_without_restart();
      test_every_mode();
      test_mode_switch_mid_message();
      test_shift_extremes();
      test_random_traffic(RANDOM_ITEMS / 2);
      test_output_backpressure();
      test_random_traffic(RANDOM_ITEMS - random_sent);

      // drain and let any trailing byte finish
      wait_for_idle();
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/mmcc_pkg.sv
src/mmcc_csr.sv
src/mmcc_alu.sv
src/multi_mode_checksum_crc16_engine.sv
bench/multi_mode_checksum_crc16_engine_test.sv
